[hw/rtl/accel_step_detector_top_assert.svh]
// assertion macros for the step detector
// used by accel_step_detector_top, needs clk and rst_n in scope
`ifndef ACCEL_STEP_DETECTOR_TOP_ASSERT_SVH
`define ACCEL_STEP_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define ASD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/asd_pkg.sv]
// shared types, constants and helpers for the step detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

    localparam int COUNT_BITS    = 24;
    localparam int TOTAL_BITS    = 24;
    localparam int AXIS_BITS     = 16;
    localparam int TIME_BITS     = 48;
    localparam int BASE_BITS     = 32;
    localparam int ROOT_BITS     = 16;
    localparam int RAD_BITS      = 2 * ROOT_BITS;
    localparam int REM_BITS      = ROOT_BITS + 2;
    localparam int SENS_BITS     = 7;
    localparam int GOAL_BITS     = 20;
    localparam int REFR_BITS     = 20;
    localparam int PCT_BITS      = 7;
    localparam int QUOT_BITS     = 7;
    localparam int THR_BITS      = 14;
    localparam int THR_SHIFT     = 29;
    localparam int ACC_BITS      = 48;
    localparam int MPLIER_BITS   = 16;
    localparam int NBITS_W       = 5;
    localparam int PROD_BITS     = COUNT_BITS + PCT_BITS;
    localparam int DSR_BITS      = GOAL_BITS + QUOT_BITS - 1;
    localparam int DIV_BITS      = (PROD_BITS > DSR_BITS) ? PROD_BITS : DSR_BITS;
    localparam int DIV_CNT_BITS  = $clog2(QUOT_BITS + 1);
    localparam int GCMP_BITS     = (COUNT_BITS > GOAL_BITS) ? COUNT_BITS : GOAL_BITS;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS + 1);

    localparam int IN_DATA_BITS  = 3 * AXIS_BITS + TIME_BITS;
    localparam int OUT_DATA_BITS = 1 + TOTAL_BITS + PCT_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SENS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GOAL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REFR = 2'd2;

    localparam logic [SENS_BITS-1:0]  SENS_RESET = 7'd100;
    localparam logic [GOAL_BITS-1:0]  GOAL_RESET = 20'd10000;
    localparam logic [REFR_BITS-1:0]  REFR_RESET = 20'd250000;
    localparam logic [BASE_BITS-1:0]  BASE_RESET = 32'h2000_0000;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

    localparam logic [MPLIER_BITS-1:0] BASE_GAIN = 16'd1311;
    localparam logic [MPLIER_BITS-1:0] THR_SCALE = 16'd9900;
    localparam logic [MPLIER_BITS-1:0] PCT_SCALE = 16'd100;
    localparam logic [PCT_BITS-1:0]    PCT_FULL  = 7'd100;

    localparam logic [NBITS_W-1:0] N_SQ   = 5'd16;
    localparam logic [NBITS_W-1:0] N_BASE = 5'd11;
    localparam logic [NBITS_W-1:0] N_THR  = 5'd14;
    localparam logic [NBITS_W-1:0] N_PCT  = 5'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_BASE,
        ST_RES,
        ST_CMP,
        ST_PCT,
        ST_PMUL,
        ST_DIV,
        ST_OUT
    } asd_state_t;

    typedef struct packed {
        logic                       start;
        logic                       clear;
        logic signed [ACC_BITS-1:0] mcand;
        logic [MPLIER_BITS-1:0]     mplier;
        logic [NBITS_W-1:0]         nbits;
    } asd_mul_req_t;

    // threshold numerator in units of 1/9900 g: 11995 - 115*sens, held at 0.05 g for sens of 100 and above
    function automatic logic [THR_BITS-1:0] thr_num(input logic [SENS_BITS-1:0] sens);
        logic [THR_BITS-1:0] prod;
        prod = THR_BITS'(sens) * 14'd115;
        if (sens >= 7'd100)
            return 14'd495;
        else
            return 14'd11995 - prod;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/accel_step_detector_top.sv]
// step detector top level: sequencer, state, config and stream ports
// uses asd_pkg, asd_mul, asd_sqrt, asd_div and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

// Takes one accelerometer sample per input beat and returns one result beat
// per sample. A sample passes through these steps: taking it in, the three
// squares through the bit-serial multiplier, the magnitude through the square
// root unit, then the baseline update, the threshold product and compare
// (skipped inside the refractory window or with no positive residual), picking
// the percentage path, the goal percentage (a product then a divide, skipped
// when the goal is zero or reached) and loading the output register.
// One sample is worked on at a time; a finished result waits in the output
// register while the next sample is taken in. Configuration writes take
// effect at once and belong between samples.

module accel_step_detector_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], time_us [95:48]
    input  wire logic [asd_pkg::IN_DATA_BITS-1:0]       s_tdata,
    // day_rollover
    input  wire logic                                   s_tuser,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // step_detected [0], step_total [24:1], goal_percent [31:25]
    output logic [asd_pkg::OUT_DATA_BITS-1:0]           m_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    input  wire logic                                   cfg_we,
    input  wire logic [asd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [asd_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import asd_pkg::*;

    `include "accel_step_detector_top_assert.svh"

    asd_state_t state_reg, state_next;

    logic [SENS_BITS-1:0]           sens_reg;
    logic [GOAL_BITS-1:0]           goal_reg;
    logic [REFR_BITS-1:0]           refr_reg;
    logic [BASE_BITS-1:0]           base_reg, base_next;
    logic [TIME_BITS-1:0]           last_reg, last_next;
    logic [COUNT_BITS-1:0]          count_reg, count_next;
    logic [2:0][AXIS_BITS-1:0]      abs_reg, abs_next;
    logic [TIME_BITS-1:0]           time_reg, time_next;
    logic [1:0]                     axis_reg, axis_next;
    logic                           issued_reg, issued_next;
    logic [ROOT_BITS-1:0]           mag_reg, mag_next;
    logic                           eok_reg, eok_next;
    logic                           det_reg, det_next;
    logic [PCT_BITS-1:0]            pct_reg, pct_next;
    logic                           mvalid_reg, mvalid_next;
    logic [OUT_DATA_BITS-1:0]       mdata_reg, mdata_next;

    logic                           s_accept;
    logic                           out_load;
    logic                           unit_busy;
    logic                           op_done;
    logic                           res_go;
    logic                           step_hit;
    logic                           goal_skip;
    logic signed [BASE_BITS:0]      diff;
    logic signed [BASE_BITS:0]      residual;
    logic [TIME_BITS-1:0]           elapsed;
    logic [2:0][AXIS_BITS-1:0]      axis_in;
    logic [2:0][AXIS_BITS-1:0]      axis_abs;

    asd_mul_req_t                   mul_req;
    logic                           mul_busy;
    logic signed [ACC_BITS-1:0]     mul_acc;
    logic                           sqrt_start;
    logic                           sqrt_busy;
    logic [ROOT_BITS-1:0]           sqrt_root;
    logic                           div_start;
    logic                           div_busy;
    logic [QUOT_BITS-1:0]           div_quot;

    asd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .busy  (mul_busy),
        .acc   (mul_acc)
    );

    asd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mul_acc[RAD_BITS-1:0]),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    asd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_acc[PROD_BITS-1:0]),
        .divisor  (goal_reg),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!mvalid_reg || m_tready);

    // absolute values of the axes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            axis_in[i]  = s_tdata[i*AXIS_BITS +: AXIS_BITS];
            axis_abs[i] = axis_in[i][AXIS_BITS-1] ? AXIS_BITS'(-axis_in[i]) : axis_in[i];
        end
    end

    assign elapsed  = s_tdata[3*AXIS_BITS +: TIME_BITS] - last_reg;
    assign diff     = $signed({1'b0, mag_reg, 16'b0}) - $signed({1'b0, base_reg});
    assign residual = diff;
    assign res_go   = eok_reg && !residual[BASE_BITS] && (residual != '0);
    assign step_hit = mul_acc > $signed(ACC_BITS'({thr_num(sens_reg), {THR_SHIFT{1'b0}}}));
    assign goal_skip = (goal_reg == '0) || (GCMP_BITS'(count_reg) >= GCMP_BITS'(goal_reg));

    always_comb
    begin
        unique case (state_reg)
            ST_SQRT: unit_busy = sqrt_busy;
            ST_DIV:  unit_busy = div_busy;
            default: unit_busy = mul_busy;
        endcase
    end

    assign op_done = issued_reg && !unit_busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_SQ;
            ST_SQ:   if (op_done && axis_reg == 2'd2) state_next = ST_SQRT;
            ST_SQRT: if (op_done) state_next = ST_BASE;
            ST_BASE: if (op_done) state_next = ST_RES;
            ST_RES:
            begin
                if (!res_go)
                    state_next = ST_PCT;
                else if (op_done)
                    state_next = ST_CMP;
            end
            ST_CMP:  state_next = ST_PCT;
            ST_PCT:  state_next = goal_skip ? ST_OUT : ST_PMUL;
            ST_PMUL: if (op_done) state_next = ST_DIV;
            ST_DIV:  if (op_done) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb
    begin
        base_next   = base_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        abs_next    = abs_reg;
        time_next   = time_reg;
        axis_next   = axis_reg;
        issued_next = issued_reg;
        mag_next    = mag_reg;
        eok_next    = eok_reg;
        det_next    = det_reg;
        pct_next    = pct_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mul_req     = '0;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    abs_next    = axis_abs;
                    time_next   = s_tdata[3*AXIS_BITS +: TIME_BITS];
                    eok_next    = elapsed >= TIME_BITS'(refr_reg);
                    det_next    = 1'b0;
                    axis_next   = 2'd0;
                    issued_next = 1'b0;
                    if (s_tuser)
                        count_next = '0;
                end
            end
            ST_SQ:
            begin
                if (!issued_reg)
                begin
                    mul_req.start  = 1'b1;
                    mul_req.clear  = (axis_reg == 2'd0);
                    mul_req.mcand  = ACC_BITS'(abs_reg[axis_reg]);
                    mul_req.mplier = abs_reg[axis_reg];
                    mul_req.nbits  = N_SQ;
                    issued_next    = 1'b1;
                end
                else if (op_done)
                begin
                    issued_next = 1'b0;
                    axis_next   = axis_reg + 1'b1;
                end
            end
            ST_SQRT:
            begin
                if (!issued_reg)
                begin
                    sqrt_start  = 1'b1;
                    issued_next = 1'b1;
                end
                else if (op_done)
                begin
                    issued_next = 1'b0;
                    mag_next    = sqrt_root;
                end
            end
            ST_BASE:
            begin
                if (!issued_reg)
                begin
                    mul_req.start  = 1'b1;
                    mul_req.clear  = 1'b1;
                    mul_req.mcand  = ACC_BITS'(diff);
                    mul_req.mplier = BASE_GAIN;
                    mul_req.nbits  = N_BASE;
                    issued_next    = 1'b1;
                end
                else if (op_done)
                begin
                    issued_next = 1'b0;
                    base_next   = base_reg + mul_acc[ACC_BITS-1:16];
                end
            end
            ST_RES:
            begin
                if (res_go && !issued_reg)
                begin
                    mul_req.start  = 1'b1;
                    mul_req.clear  = 1'b1;
                    mul_req.mcand  = ACC_BITS'(residual);
                    mul_req.mplier = THR_SCALE;
                    mul_req.nbits  = N_THR;
                    issued_next    = 1'b1;
                end
                else if (op_done)
                    issued_next = 1'b0;
            end
            ST_CMP:
            begin
                if (step_hit)
                begin
                    det_next  = 1'b1;
                    last_next = time_reg;
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + 1'b1;
                end
            end
            ST_PCT:
            begin
                pct_next = (goal_reg == '0) ? '0 : PCT_FULL;
            end
            ST_PMUL:
            begin
                if (!issued_reg)
                begin
                    mul_req.start  = 1'b1;
                    mul_req.clear  = 1'b1;
                    mul_req.mcand  = ACC_BITS'(count_reg);
                    mul_req.mplier = PCT_SCALE;
                    mul_req.nbits  = N_PCT;
                    issued_next    = 1'b1;
                end
                else if (op_done)
                    issued_next = 1'b0;
            end
            ST_DIV:
            begin
                if (!issued_reg)
                begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (op_done)
                begin
                    issued_next = 1'b0;
                    pct_next    = div_quot;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {pct_reg, TOTAL_BITS'(count_reg), det_reg};
                end
            end
            default:
            begin
                issued_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sens_reg   <= SENS_RESET;
            goal_reg   <= GOAL_RESET;
            refr_reg   <= REFR_RESET;
            base_reg   <= BASE_RESET;
            last_reg   <= '0;
            count_reg  <= '0;
            axis_reg   <= '0;
            issued_reg <= 1'b0;
            det_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            last_reg   <= last_next;
            count_reg  <= count_next;
            axis_reg   <= axis_next;
            issued_reg <= issued_next;
            det_reg    <= det_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SENS: sens_reg <= cfg_data[SENS_BITS-1:0];
                    CFG_GOAL: goal_reg <= cfg_data[GOAL_BITS-1:0];
                    CFG_REFR: refr_reg <= cfg_data[REFR_BITS-1:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg   <= abs_next;
        time_reg  <= time_next;
        mag_reg   <= mag_next;
        eok_reg   <= eok_next;
        pct_reg   <= pct_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    `ASD_ASSERT_IMP(a_step_has_count, out_load && det_reg, count_reg != '0, "step beat with zero count")
    `ASD_ASSERT_IMP(a_pct_capped, m_tvalid, m_tdata[OUT_DATA_BITS-1 -: PCT_BITS] <= PCT_FULL, "percent above cap")
    `ASD_ASSERT_NXT(a_accept_leaves_idle, s_accept, state_reg == ST_SQ, "sample not started")
    `ASD_ASSERT_IMP(a_mul_no_relaunch, mul_req.start, !mul_busy, "multiplier started while busy")

endmodule

`default_nettype wire

[hw/rtl/asd_mul.sv]
// bit-serial shift-add multiplier with accumulator
// uses asd_pkg
`timescale 1ns / 1ps
`default_nettype none

module asd_mul (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire asd_pkg::asd_mul_req_t              req,
    output logic                                    busy,
    output logic signed [asd_pkg::ACC_BITS-1:0]     acc
);
    import asd_pkg::*;

    logic signed [ACC_BITS-1:0] mcand_reg, mcand_next;
    logic [MPLIER_BITS-1:0]     mplier_reg, mplier_next;
    logic [NBITS_W-1:0]         cnt_reg, cnt_next;
    logic signed [ACC_BITS-1:0] acc_reg, acc_next;

    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        if (req.start)
        begin
            mcand_next  = req.mcand;
            mplier_next = req.mplier;
            cnt_next    = req.nbits;
            if (req.clear)
                acc_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign busy = (cnt_reg != '0);
    assign acc  = acc_reg;

endmodule

`default_nettype wire

[hw/rtl/asd_sqrt.sv]
// bit-serial integer square root, two radicand bits per cycle
// uses asd_pkg
`timescale 1ns / 1ps
`default_nettype none

module asd_sqrt (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [asd_pkg::RAD_BITS-1:0]   radicand,
    output logic                                busy,
    output logic [asd_pkg::ROOT_BITS-1:0]       root
);
    import asd_pkg::*;

    logic [RAD_BITS-1:0]      rad_reg, rad_next;
    logic [REM_BITS-1:0]      rem_reg, rem_next;
    logic [ROOT_BITS-1:0]     root_reg, root_next;
    logic [ROOT_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [REM_BITS-1:0]      rem_sh;
    logic [REM_BITS-1:0]      trial;

    assign rem_sh = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1:RAD_BITS-2]};
    assign trial  = {root_reg, 2'b01};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = ROOT_CNT_BITS'(ROOT_BITS);
        end
        else if (cnt_reg != '0)
        begin
            rad_next = rad_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

endmodule

`default_nettype wire

[hw/rtl/asd_div.sv]
// restoring divider, one quotient bit per cycle, short quotient
// uses asd_pkg
`timescale 1ns / 1ps
`default_nettype none

module asd_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [asd_pkg::PROD_BITS-1:0]  dividend,
    input  wire logic [asd_pkg::GOAL_BITS-1:0]  divisor,
    output logic                                busy,
    output logic [asd_pkg::QUOT_BITS-1:0]       quot
);
    import asd_pkg::*;

    logic [DIV_BITS-1:0]     rem_reg, rem_next;
    logic [DIV_BITS-1:0]     dsr_reg, dsr_next;
    logic [QUOT_BITS-1:0]    q_reg, q_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = DIV_BITS'(dividend);
            dsr_next = DIV_BITS'(divisor) << (QUOT_BITS - 1);
            q_next   = '0;
            cnt_next = DIV_CNT_BITS'(QUOT_BITS);
        end
        else if (cnt_reg != '0)
        begin
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (rem_reg >= dsr_reg)
            begin
                rem_next = rem_reg - dsr_reg;
                q_next   = {q_reg[QUOT_BITS-2:0], 1'b1};
            end
            else
                q_next   = {q_reg[QUOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;

endmodule

`default_nettype wire
